// ===== rtl/gpr_pkg.sv =====
`default_nettype none

package gpr_pkg;

  // fixed field widths of one command beat and one result beat
  localparam int unsigned CmdW   = 4;
  localparam int unsigned PortW  = 2;
  localparam int unsigned PinW   = 4;
  localparam int unsigned ValueW = 16;
  localparam int unsigned PadW   = 16;
  localparam int unsigned WordW  = 16;

  // per-pin field widths
  localparam int unsigned Field2W = 2;
  localparam int unsigned Field4W = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_MODE      = 4'd0,
    CMD_OUTTYPE   = 4'd1,
    CMD_SPEED     = 4'd2,
    CMD_PULL      = 4'd3,
    CMD_READ      = 4'd4,
    CMD_WRITEPIN  = 4'd5,
    CMD_WRITEPORT = 4'd6,
    CMD_TOGGLE    = 4'd7,
    CMD_ATOMIC    = 4'd8,
    CMD_ALTFUNC   = 4'd9
  } cmd_e;

  typedef struct packed {
    logic               read_bit;
    logic [WordW-1:0]   port_output;
    logic [Field2W-1:0] pin_mode;
    logic               pin_open_drain;
    logic [Field2W-1:0] pin_speed;
    logic [Field2W-1:0] pin_pull;
    logic [Field4W-1:0] pin_alt_function;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/gpr_exec.sv =====
`default_nettype none

// read-modify-write of one port's register words for one command
module gpr_exec #(
  parameter int unsigned PINS_PER_PORT = 16
) (
  input  wire logic [gpr_pkg::CmdW-1:0]         cmd_i,
  input  wire logic [gpr_pkg::PinW-1:0]         pin_i,
  input  wire logic [gpr_pkg::ValueW-1:0]       value_i,
  input  wire logic [gpr_pkg::PadW-1:0]         pads_i,
  input  wire logic [2*PINS_PER_PORT-1:0]       mode_i,
  input  wire logic [PINS_PER_PORT-1:0]         drain_i,
  input  wire logic [2*PINS_PER_PORT-1:0]       speed_i,
  input  wire logic [2*PINS_PER_PORT-1:0]       pull_i,
  input  wire logic [PINS_PER_PORT-1:0]         odr_i,
  input  wire logic [4*PINS_PER_PORT-1:0]       af_i,
  output logic      [2*PINS_PER_PORT-1:0]       mode_o,
  output logic      [PINS_PER_PORT-1:0]         drain_o,
  output logic      [2*PINS_PER_PORT-1:0]       speed_o,
  output logic      [2*PINS_PER_PORT-1:0]       pull_o,
  output logic      [PINS_PER_PORT-1:0]         odr_o,
  output logic      [4*PINS_PER_PORT-1:0]       af_o,
  output gpr_pkg::res_t                         res_o
);

  localparam int unsigned IdxW = (PINS_PER_PORT > 1) ? $clog2(PINS_PER_PORT) : 1;

  gpr_pkg::cmd_e   cmd;
  logic            pin_ok;
  logic [IdxW-1:0] idx;
  logic            fits2;
  logic            fits4;
  logic            is_zero;
  logic            is_one;

  assign cmd     = gpr_pkg::cmd_e'(cmd_i);
  assign pin_ok  = {1'b0, pin_i} < (gpr_pkg::PinW+1)'(PINS_PER_PORT);
  assign idx     = IdxW'(pin_i);
  assign fits2   = (value_i[gpr_pkg::ValueW-1:gpr_pkg::Field2W] == '0);
  assign fits4   = (value_i[gpr_pkg::ValueW-1:gpr_pkg::Field4W] == '0);
  assign is_zero = (value_i == '0);
  assign is_one  = (value_i == gpr_pkg::ValueW'(1));

  always_comb begin
    mode_o  = mode_i;
    drain_o = drain_i;
    speed_o = speed_i;
    pull_o  = pull_i;
    odr_o   = odr_i;
    af_o    = af_i;
    if (pin_ok) begin
      case (cmd)
        gpr_pkg::CMD_MODE: begin
          if (fits2) mode_o[idx*2 +: 2] = value_i[1:0];
        end
        gpr_pkg::CMD_OUTTYPE: begin
          if (is_zero || is_one) drain_o[idx] = value_i[0];
        end
        gpr_pkg::CMD_SPEED: begin
          if (fits2) speed_o[idx*2 +: 2] = value_i[1:0];
        end
        gpr_pkg::CMD_PULL: begin
          if (fits2) pull_o[idx*2 +: 2] = value_i[1:0];
        end
        // atomic set and reset land like a pin write: value 0 clears, value 1 sets the pin's output bit
        gpr_pkg::CMD_WRITEPIN, gpr_pkg::CMD_ATOMIC: begin
          if (is_zero || is_one) odr_o[idx] = value_i[0];
        end
        gpr_pkg::CMD_TOGGLE: begin
          odr_o[idx] = ~odr_i[idx];
        end
        gpr_pkg::CMD_ALTFUNC: begin
          if (fits4) af_o[idx*4 +: 4] = value_i[3:0];
        end
        default: begin
        end
      endcase
    end
    if (cmd == gpr_pkg::CMD_WRITEPORT) odr_o = value_i[PINS_PER_PORT-1:0];
  end

  always_comb begin
    res_o             = '0;
    res_o.port_output = gpr_pkg::WordW'(odr_o);
    if (pin_ok) begin
      res_o.read_bit         = (cmd == gpr_pkg::CMD_READ) && pads_i[pin_i];
      res_o.pin_mode         = mode_o[idx*2 +: 2];
      res_o.pin_open_drain   = drain_o[idx];
      res_o.pin_speed        = speed_o[idx*2 +: 2];
      res_o.pin_pull         = pull_o[idx*2 +: 2];
      res_o.pin_alt_function = af_o[idx*4 +: 4];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gpio_port_register_block.sv =====
`default_nettype none

// channel  | handshake                    | payload
// ---------+------------------------------+----------------------------------------------
// command  | in_valid_i / in_ready_o      | command_i port_i pin_i value_i pad_levels_i
// result   | out_valid_o / out_ready_i    | read_bit_o port_output_o pin_*_o
//
// one command beat per clock sustained while results are drained; a result is offered once its
// command beat has passed through the command register, then the result register
// the port's register words are read, modified and written back as a command
// moves from the command register into the result register, so commands act in order
// reset clears every register word of every port and empties both stages
// a stalled result holds in the result register; one more command waits in the
// command register, and in_ready_o falls only when both are full
module gpio_port_register_block #(
  parameter int unsigned NUM_PORTS     = 3,
  parameter int unsigned PINS_PER_PORT = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [gpr_pkg::CmdW-1:0]      command_i,
  input  wire logic [gpr_pkg::PortW-1:0]     port_i,
  input  wire logic [gpr_pkg::PinW-1:0]      pin_i,
  input  wire logic [gpr_pkg::ValueW-1:0]    value_i,
  input  wire logic [gpr_pkg::PadW-1:0]      pad_levels_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               read_bit_o,
  output logic [gpr_pkg::WordW-1:0]          port_output_o,
  output logic [gpr_pkg::Field2W-1:0]        pin_mode_o,
  output logic                               pin_open_drain_o,
  output logic [gpr_pkg::Field2W-1:0]        pin_speed_o,
  output logic [gpr_pkg::Field2W-1:0]        pin_pull_o,
  output logic [gpr_pkg::Field4W-1:0]        pin_alt_function_o
);

  localparam int unsigned SelW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int unsigned P    = PINS_PER_PORT;

  // per-port register file
  logic [2*P-1:0] mode_q  [NUM_PORTS];
  logic [P-1:0]   drain_q [NUM_PORTS];
  logic [2*P-1:0] speed_q [NUM_PORTS];
  logic [2*P-1:0] pull_q  [NUM_PORTS];
  logic [P-1:0]   odr_q   [NUM_PORTS];
  logic [4*P-1:0] af_q    [NUM_PORTS];

  // command stage
  logic                         in_valid_q;
  logic [gpr_pkg::CmdW-1:0]     cmd_q;
  logic [gpr_pkg::PortW-1:0]    port_q;
  logic [gpr_pkg::PinW-1:0]     pin_q;
  logic [gpr_pkg::ValueW-1:0]   value_q;
  logic [gpr_pkg::PadW-1:0]     pads_q;

  // result stage
  logic                         out_valid_q;
  gpr_pkg::res_t                res_q;
  gpr_pkg::res_t                res_d;
  gpr_pkg::res_t                exec_res;

  logic            advance;
  logic            port_ok;
  logic [SelW-1:0] sel;

  // words of the addressed port, before and after the command
  logic [2*P-1:0] mode_rd,  mode_wr;
  logic [P-1:0]   drain_rd, drain_wr;
  logic [2*P-1:0] speed_rd, speed_wr;
  logic [2*P-1:0] pull_rd,  pull_wr;
  logic [P-1:0]   odr_rd,   odr_wr;
  logic [4*P-1:0] af_rd,    af_wr;

  // the command stage moves on when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // an unknown port changes nothing and reports all zeros
  assign port_ok = {2'b00, port_q} < (gpr_pkg::PortW+2)'(NUM_PORTS);
  assign sel     = SelW'(port_q);

  assign mode_rd  = port_ok ? mode_q[sel]  : '0;
  assign drain_rd = port_ok ? drain_q[sel] : '0;
  assign speed_rd = port_ok ? speed_q[sel] : '0;
  assign pull_rd  = port_ok ? pull_q[sel]  : '0;
  assign odr_rd   = port_ok ? odr_q[sel]   : '0;
  assign af_rd    = port_ok ? af_q[sel]    : '0;

  gpr_exec #(
    .PINS_PER_PORT(P)
  ) u_exec (
    .cmd_i   (cmd_q),
    .pin_i   (pin_q),
    .value_i (value_q),
    .pads_i  (pads_q),
    .mode_i  (mode_rd),
    .drain_i (drain_rd),
    .speed_i (speed_rd),
    .pull_i  (pull_rd),
    .odr_i   (odr_rd),
    .af_i    (af_rd),
    .mode_o  (mode_wr),
    .drain_o (drain_wr),
    .speed_o (speed_wr),
    .pull_o  (pull_wr),
    .odr_o   (odr_wr),
    .af_o    (af_wr),
    .res_o   (exec_res)
  );

  assign res_d = port_ok ? exec_res : '0;

  // register words, written back as the command retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        mode_q[i]  <= '0;
        drain_q[i] <= '0;
        speed_q[i] <= '0;
        pull_q[i]  <= '0;
        odr_q[i]   <= '0;
        af_q[i]    <= '0;
      end
    end else if (advance && port_ok) begin
      mode_q[sel]  <= mode_wr;
      drain_q[sel] <= drain_wr;
      speed_q[sel] <= speed_wr;
      pull_q[sel]  <= pull_wr;
      odr_q[sel]   <= odr_wr;
      af_q[sel]    <= af_wr;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= command_i;
      port_q  <= port_i;
      pin_q   <= pin_i;
      value_q <= value_i;
      pads_q  <= pad_levels_i;
    end
    if (advance) res_q <= res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign read_bit_o         = res_q.read_bit;
  assign port_output_o      = res_q.port_output;
  assign pin_mode_o         = res_q.pin_mode;
  assign pin_open_drain_o   = res_q.pin_open_drain;
  assign pin_speed_o        = res_q.pin_speed;
  assign pin_pull_o         = res_q.pin_pull;
  assign pin_alt_function_o = res_q.pin_alt_function;

endmodule

`default_nettype wire
